FILE: rtl/core/base64_stream_encoder_assert.svh
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define B64E_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define B64E_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define B64E_ASSERT(lbl, ck, rs, prop, msg)
`define B64E_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

FILE: rtl/core/b64e_pkg.sv
package b64e_pkg;

  // default number of entries between front and back
  localparam int B64E_QUEUE_DEPTH = 2;

  // ascii pad character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [7:0] code_char;
    logic       final_char;
  } out_item_t;

  // one classified byte: up to four characters ready to send
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } entry_t;

  // front status
  typedef struct packed {
    logic group_start;
  } front_status_t;

  // back status
  typedef struct packed {
    logic [1:0] char_idx;
    logic       pop;
  } back_status_t;

  // map a sextet onto the standard alphabet
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] wide;
    logic [7:0] res;
    wide = {2'b00, v};
    if (v < 6'd26) begin
      res = 8'h41 + wide;
    end else if (v < 6'd52) begin
      res = 8'h61 + wide - 8'd26;
    end else if (v < 6'd62) begin
      res = 8'h30 + wide - 8'd52;
    end else if (v == 6'd62) begin
      res = 8'h2B;
    end else begin
      res = 8'h2F;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/base64_stream_encoder.sv
// a byte's characters pass through the queue and then the output register
// throughput: one character per cycle while char_stall is low, set by the single output
//   register; a byte yields one to four characters (one or two, three for a phase-1
//   final byte, four for a phase-0 final byte)
// a two-entry queue lets bytes be accepted while earlier characters are still sent
// reset (rst, synchronous, active high) empties the queue and returns to group start
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QueueDepth = B64E_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_item,
  output logic      char_valid,
  input  logic      char_stall,
  output out_item_t char_item
);

  entry_t        push_entry;
  entry_t        q_head;
  logic          push;
  logic          q_valid;
  logic          q_full;
  front_status_t f_stat;
  back_status_t  b_stat;
  logic          last_taken;
  logic          idx_ok;

  // byte intake and classification
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .queue_full (q_full),
    .push       (push),
    .entry      (push_entry),
    .status     (f_stat)
  );

  // entries between front and back
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (b_stat.pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  // character output
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .status     (b_stat)
  );

  // terms for the checks
  assign last_taken = byte_valid && !byte_stall && byte_item.end_of_message;
  assign idx_ok     = !q_valid || (b_stat.char_idx <= q_head.last_idx);

  // checks
  `B64E_ASSERT_NEXT(a_last_restart, clk, rst, last_taken, f_stat.group_start, "no group restart")
  `B64E_ASSERT(a_idx_in_entry, clk, rst, idx_ok, "character index past end of entry")
  `B64E_ASSERT(a_pop_needs_entry, clk, rst, !b_stat.pop || q_valid, "pop from empty queue")

endmodule

FILE: rtl/core/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  in_item_t      byte_item,
  input  logic          queue_full,
  output logic          push,
  output entry_t        entry,
  output front_status_t status
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  // accept while the queue has room
  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;
  assign status.group_start = (phase == PH_FIRST);

  // classify the byte into its characters and the next group position
  always_comb begin
    logic [7:0] b;
    logic       last;
    b             = byte_item.data_byte;
    last          = byte_item.end_of_message;
    entry.chars   = '0;
    entry.last_idx = 2'd0;
    entry.fin     = last;
    phase_next    = phase;
    leftover_next = leftover;
    unique case (phase)
      PH_SECOND: begin
        entry.chars[0] = sym({leftover[1:0], b[7:4]});
        if (last) begin
          entry.chars[1] = sym({b[3:0], 2'b00});
          entry.chars[2] = PAD_CHAR;
          entry.last_idx = 2'd2;
        end else begin
          leftover_next = b[3:0];
          phase_next    = PH_THIRD;
        end
      end
      PH_THIRD: begin
        entry.chars[0] = sym({leftover, b[7:6]});
        entry.chars[1] = sym(b[5:0]);
        entry.last_idx = 2'd1;
        leftover_next  = 4'd0;
        phase_next     = PH_FIRST;
      end
      default: begin
        entry.chars[0] = sym(b[7:2]);
        if (last) begin
          entry.chars[1] = sym({b[1:0], 4'b0000});
          entry.chars[2] = PAD_CHAR;
          entry.chars[3] = PAD_CHAR;
          entry.last_idx = 2'd3;
        end else begin
          leftover_next = {2'b00, b[1:0]};
          phase_next    = PH_SECOND;
        end
      end
    endcase
    if (last) begin
      phase_next    = PH_FIRST;
      leftover_next = 4'd0;
    end
  end

  // group position and leftover bits
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

FILE: rtl/core/b64e_queue.sv
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int Depth = B64E_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   head_valid,
  output logic   full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t             slots [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CntW'(Depth));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/b64e_back.sv
module b64e_back
  import b64e_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  entry_t       head,
  input  logic         head_valid,
  output logic         char_valid,
  input  logic         char_stall,
  output out_item_t    char_item,
  output back_status_t status
);

  logic [1:0] char_idx;
  logic       load;
  logic       at_last;

  // output register takes a new character when empty or being drained
  assign load    = head_valid && (!char_valid || !char_stall);
  assign at_last = (char_idx == head.last_idx);
  assign status.char_idx = char_idx;
  assign status.pop      = load && at_last;

  // output register and character index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      char_idx   <= 2'd0;
    end else if (load) begin
      char_valid           <= 1'b1;
      char_item.code_char  <= head.chars[char_idx];
      char_item.final_char <= head.fin && at_last;
      char_idx             <= at_last ? 2'd0 : char_idx + 2'd1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
  import b64e_pkg::*;

  // group positions of the next byte
  localparam logic [1:0] GRP_FIRST  = 2'd0;
  localparam logic [1:0] GRP_SECOND = 2'd1;
  localparam logic [1:0] GRP_THIRD  = 2'd2;

  localparam int TOTAL_BYTES = 320;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  // stretches of the byte stream, counted in accepted bytes
  localparam int QUIET_FIRST = 100;
  localparam int QUIET_LAST  = 160;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LAST   = 230;
  localparam int DRAIN_AT    = 260;

  // tracks the encoder state and the characters still owed
  class b64_scoreboard;
    out_item_t owed_q[$];
    logic [1:0] grp_pos;
    logic [3:0] carry_bits;
    string      alphabet;
    int         errors;
    int         bytes_seen;
    int         msgs_seen;
    int         chars_seen;
    int         tail_in_pos[3];

    function new();
      alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      grp_pos    = GRP_FIRST;
      carry_bits = 4'd0;
      errors     = 0;
      bytes_seen = 0;
      msgs_seen  = 0;
      chars_seen = 0;
      foreach (tail_in_pos[i]) tail_in_pos[i] = 0;
    endfunction

    function logic [7:0] letter(logic [5:0] v);
      return alphabet[v];
    endfunction

    function void owe(logic [7:0] ch, logic fin);
      out_item_t o;
      o.code_char  = ch;
      o.final_char = fin;
      owed_q.insert(owed_q.size(), o);
    endfunction

    // accepted byte: queue the characters it completes
    function void note_byte(in_item_t it);
      logic [7:0] b;
      logic       last;
      b    = it.data_byte;
      last = it.end_of_message;
      bytes_seen++;
      if (last && grp_pos <= GRP_THIRD) tail_in_pos[grp_pos]++;
      case (grp_pos)
        GRP_SECOND: begin
          owe(letter({carry_bits[1:0], b[7:4]}), 1'b0);
          if (last) begin
            owe(letter({b[3:0], 2'b00}), 1'b0);
            owe(PAD_CHAR, 1'b1);
          end else begin
            carry_bits = b[3:0];
            grp_pos = GRP_THIRD;
          end
        end
        GRP_THIRD: begin
          owe(letter({carry_bits, b[7:6]}), 1'b0);
          owe(letter(b[5:0]), last);
          carry_bits = 4'd0;
          grp_pos = GRP_FIRST;
        end
        default: begin
          owe(letter(b[7:2]), 1'b0);
          if (last) begin
            owe(letter({b[1:0], 4'b0000}), 1'b0);
            owe(PAD_CHAR, 1'b0);
            owe(PAD_CHAR, 1'b1);
          end else begin
            carry_bits = {2'b00, b[1:0]};
            grp_pos = GRP_SECOND;
          end
        end
      endcase
      if (last) begin
        grp_pos = GRP_FIRST;
        carry_bits = 4'd0;
        msgs_seen++;
      end
    endfunction

    // accepted character: compare with the oldest owed one
    function void check_char(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected character: code_char actual %h final_char actual %b",
               got.code_char, got.final_char);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      chars_seen++;
      if (got.code_char !== want.code_char) begin
        $error("code_char expected %h actual %h", want.code_char, got.code_char);
        errors++;
      end
      if (got.final_char !== want.final_char) begin
        $error("final_char expected %b actual %b", want.final_char, got.final_char);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  byte_item;
  logic      char_valid;
  logic      char_stall;
  out_item_t char_item;

  b64_scoreboard sb = new();
  int  sent;
  bit  hold_req;
  bit  hold_issued;
  bit  drain_done;
  int  hold_left;
  int  quiet_cycles;

  base64_stream_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // both transactions are taken at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(byte_item);
      if (char_valid && !char_stall) sb.check_char(char_item);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d characters owed",
                 STALL_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // character side: random stall, a quiet stretch and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        char_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        char_stall <= 1'b1;
      end else if (sent >= QUIET_FIRST && sent < QUIET_LAST) begin
        char_stall <= 1'b0;
      end else begin
        char_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  // offer one byte, called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic last);
    bit may_idle;
    in_item_t it;
    may_idle = !((sent >= QUIET_FIRST && sent < QUIET_LAST) ||
                 (sent >= HOLD_AT && sent < HOLD_LAST));
    if (sent == HOLD_AT && !hold_issued) begin
      hold_issued = 1'b1;
      hold_req = 1'b1;
    end
    // one pause until every owed character has come out
    if (sent == DRAIN_AT && !drain_done) begin
      drain_done = 1'b1;
      byte_valid <= 1'b0;
      do @(negedge clk); while (sb.pending() != 0);
    end else if (may_idle && $urandom_range(99) < 38) begin
      byte_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 38);
    end
    it.data_byte = data;
    it.end_of_message = last;
    byte_item  <= it;
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
    sent++;
    @(negedge clk);
  endtask

  // mostly random bytes with the extremes mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int len;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    char_stall = 1'b0;
    sent = 0;
    hold_req = 1'b0;
    hold_issued = 1'b0;
    drain_done = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-byte messages: final byte at group start, two pads
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two-byte messages: final byte in second position, one pad
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // three-byte messages: full group, no pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // all '+' group, then a lone byte
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h80, 1'b1);
    // text group then two more
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);

    // random messages, mostly short
    while (sent < TOTAL_BYTES) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 7) : $urandom_range(8, 24);
      for (int i = 0; i < len; i++) begin
        send_byte(pick_byte(), i == len - 1);
      end
    end
    byte_valid <= 1'b0;

    // drain, then watch for stray characters
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d bytes in %0d messages, %0d characters checked",
             sb.bytes_seen, sb.msgs_seen, sb.chars_seen);
    $display("final byte at group position 0/1/2: %0d/%0d/%0d",
             sb.tail_in_pos[0], sb.tail_in_pos[1], sb.tail_in_pos[2]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
